@@ src/csm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the CSR sparse matrix engine.
// No dependencies; every other file in src uses it by scoped names.
package csm_pkg;

  localparam int ROWS      = 64;
  localparam int COLS      = 64;
  localparam int NNZ       = 1024;
  localparam int FRAC_BITS = 16;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int SLOT_W = 10;
  localparam int PTR_W  = 11;
  localparam int VAL_W  = 32;
  localparam int RC_W   = 7;
  localparam int REQ_W  = 3;
  localparam int STS_W  = 2;

  localparam int PROD_W = 2 * VAL_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;

  localparam logic [RC_W-1:0]  ROW_COUNT_RST = RC_W'(64);
  localparam logic [PTR_W-1:0] NNZ_PTR       = PTR_W'(NNZ);
  localparam logic [VAL_W-1:0] VAL_MAX       = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN       = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_MUL = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_X   = 3'd0,
    REQ_LOAD_END = 3'd1,
    REQ_LOAD_COL = 3'd2,
    REQ_SET      = 3'd3,
    REQ_ADD      = 3'd4,
    REQ_GET      = 3'd5,
    REQ_MUL      = 3'd6
  } req_type_t;

  typedef enum logic [STS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ROW       = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_SAT       = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_START,
    ST_END,
    ST_SCAN,
    ST_CHECK,
    ST_MUL,
    ST_ACC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [SLOT_W-1:0]  slot;
    logic [PTR_W-1:0]   pointer;
    logic [VAL_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [ROW_W-1:0]  row;
    logic              kind;
    status_t           status;
  } res_t;

  typedef struct packed {
    logic               x_we;
    logic               x_re;
    logic [COL_W-1:0]   x_addr;
    logic [VAL_W-1:0]   x_wdata;
    logic               end_we;
    logic               end_re;
    logic [ROW_W-1:0]   end_addr;
    logic [PTR_W-1:0]   end_wdata;
    logic               slot_we;
    logic               slot_re;
    logic               val_we;
    logic [SLOT_W-1:0]  slot_addr;
    logic [COL_W-1:0]   col_wdata;
    logic [VAL_W-1:0]   val_wdata;
  } mem_req_t;

  typedef struct packed {
    logic               busy;
    logic [VAL_W-1:0]   x_rdata;
    logic [PTR_W-1:0]   end_rdata;
    logic               col_valid;
    logic [COL_W-1:0]   col_idx;
    logic [VAL_W-1:0]   val_rdata;
  } mem_rsp_t;

  typedef struct packed {
    logic mul_en;
    logic sel_acc;
  } alu_ctl_t;

endpackage

@@ src/csm_store.sv @@
`timescale 1ns / 1ps
// Matrix and vector storage: x vector, row end pointers, slot columns, slot values.
// Depends on csm_pkg. Runs the column clearing pass after reset.
module csm_store (
  input  logic               clk,
  input  logic               rst_n,
  input  csm_pkg::mem_req_t  req,
  output csm_pkg::mem_rsp_t  rsp
);

  logic [csm_pkg::VAL_W-1:0] x_mem   [csm_pkg::COLS];
  logic [csm_pkg::PTR_W-1:0] end_mem [csm_pkg::ROWS];
  logic [csm_pkg::COL_W:0]   col_mem [csm_pkg::NNZ];   // {valid, column}
  logic [csm_pkg::VAL_W-1:0] val_mem [csm_pkg::NNZ];

  logic [csm_pkg::ROWS-1:0]   end_vld_r;
  logic [csm_pkg::PTR_W-1:0]  clr_cnt_r;
  logic [csm_pkg::PTR_W-1:0]  clr_cnt_nxt;
  logic                       clr_busy;

  logic                        col_we;
  logic [csm_pkg::SLOT_W-1:0]  col_waddr;
  logic [csm_pkg::COL_W:0]     col_wdata;

  logic [csm_pkg::VAL_W-1:0]  x_q_r;
  logic [csm_pkg::PTR_W-1:0]  end_q_r;
  logic                       end_vld_q_r;
  logic [csm_pkg::COL_W:0]    col_q_r;
  logic [csm_pkg::VAL_W-1:0]  val_q_r;

  // Clearing pass: one slot per cycle until every slot reads empty.
  assign clr_busy    = (clr_cnt_r != csm_pkg::NNZ_PTR);
  assign clr_cnt_nxt = clr_busy ? clr_cnt_r + csm_pkg::PTR_W'(1) : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    if (clr_busy) begin
      col_we    = 1'b1;
      col_waddr = clr_cnt_r[csm_pkg::SLOT_W-1:0];
      col_wdata = '0;
    end else begin
      col_we    = req.slot_we;
      col_waddr = req.slot_addr;
      col_wdata = {1'b1, req.col_wdata};
    end
  end

  always_ff @(posedge clk) begin
    if (req.x_we) begin
      x_mem[req.x_addr] <= req.x_wdata;
    end
    if (req.x_re) begin
      x_q_r <= x_mem[req.x_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.end_we) begin
      end_mem[req.end_addr] <= req.end_wdata;
    end
    if (req.end_re) begin
      end_q_r     <= end_mem[req.end_addr];
      end_vld_q_r <= end_vld_r[req.end_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_vld_r <= '0;
    end else if (req.end_we) begin
      end_vld_r[req.end_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    if (req.slot_re) begin
      col_q_r <= col_mem[req.slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.val_we) begin
      val_mem[req.slot_addr] <= req.val_wdata;
    end
    if (req.slot_re) begin
      val_q_r <= val_mem[req.slot_addr];
    end
  end

  always_comb begin
    rsp.busy      = clr_busy;
    rsp.x_rdata   = x_q_r;
    rsp.end_rdata = end_vld_q_r ? end_q_r : '0;   // never-written row end reads as zero
    rsp.col_valid = col_q_r[csm_pkg::COL_W];
    rsp.col_idx   = col_q_r[csm_pkg::COL_W-1:0];
    rsp.val_rdata = val_q_r;
  end

endmodule

@@ src/csm_alu.sv @@
`timescale 1ns / 1ps
// Shared arithmetic unit: registered Q16.16 multiply and one saturating adder.
// Depends on csm_pkg.
module csm_alu (
  input  logic                       clk,
  input  csm_pkg::alu_ctl_t          ctl,
  input  logic [csm_pkg::VAL_W-1:0]  mul_a,
  input  logic [csm_pkg::VAL_W-1:0]  mul_b,
  input  logic [csm_pkg::VAL_W-1:0]  add_a,
  input  logic [csm_pkg::VAL_W-1:0]  add_b,
  output logic [csm_pkg::VAL_W-1:0]  sum,
  output logic                       sat
);

  logic signed [csm_pkg::PROD_W-1:0]          prod_r;
  logic signed [csm_pkg::PROD_W-1:0]          prod_sh;
  logic [csm_pkg::TERM_W-1:0]                 term_wide;
  logic [csm_pkg::TERM_W-csm_pkg::VAL_W:0]    term_hi;
  logic                                       term_ok;
  logic [csm_pkg::VAL_W-1:0]                  term;
  logic [csm_pkg::VAL_W-1:0]                  opd_b;
  logic [csm_pkg::VAL_W:0]                    sum_w;
  logic                                       ovf;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= $signed(mul_a) * $signed(mul_b);
    end
  end

  // Drop fraction bits (floor), then clamp the term to 32 bits.
  assign prod_sh   = prod_r >>> csm_pkg::FRAC_BITS;
  assign term_wide = prod_sh[csm_pkg::TERM_W-1:0];
  assign term_hi   = term_wide[csm_pkg::TERM_W-1:csm_pkg::VAL_W-1];
  assign term_ok   = (&term_hi) | ~(|term_hi);

  always_comb begin
    if (term_ok) begin
      term = term_wide[csm_pkg::VAL_W-1:0];
    end else if (term_wide[csm_pkg::TERM_W-1]) begin
      term = csm_pkg::VAL_MIN;
    end else begin
      term = csm_pkg::VAL_MAX;
    end
  end

  assign opd_b = ctl.sel_acc ? term : add_b;
  assign sum_w = {add_a[csm_pkg::VAL_W-1], add_a} + {opd_b[csm_pkg::VAL_W-1], opd_b};
  assign ovf   = sum_w[csm_pkg::VAL_W] ^ sum_w[csm_pkg::VAL_W-1];

  always_comb begin
    if (!ovf) begin
      sum = sum_w[csm_pkg::VAL_W-1:0];
    end else if (sum_w[csm_pkg::VAL_W]) begin
      sum = csm_pkg::VAL_MIN;
    end else begin
      sum = csm_pkg::VAL_MAX;
    end
  end

  assign sat = ovf | (ctl.sel_acc & ~term_ok);

endmodule

@@ src/csm_ctrl.sv @@
`timescale 1ns / 1ps
// Request sequencer: decodes an item, walks the row's slots one at a time.
// Depends on csm_pkg; drives csm_store and csm_alu.
module csm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  csm_pkg::req_t              in_req,
  input  logic [csm_pkg::RC_W-1:0]   row_count,
  input  csm_pkg::mem_rsp_t          rsp,
  output csm_pkg::mem_req_t          mreq,
  output csm_pkg::alu_ctl_t          actl,
  output logic [csm_pkg::VAL_W-1:0]  mul_a,
  output logic [csm_pkg::VAL_W-1:0]  mul_b,
  output logic [csm_pkg::VAL_W-1:0]  add_a,
  output logic [csm_pkg::VAL_W-1:0]  add_b,
  input  logic [csm_pkg::VAL_W-1:0]  alu_sum,
  input  logic                       alu_sat,
  output logic                       res_valid,
  input  logic                       res_ready,
  output csm_pkg::res_t              res
);

  csm_pkg::state_t            state_r;
  csm_pkg::state_t            state_nxt;
  csm_pkg::req_t              req_r;
  csm_pkg::res_t              res_r;
  logic [csm_pkg::PTR_W-1:0]  k_r;
  logic [csm_pkg::PTR_W-1:0]  end_r;
  logic [csm_pkg::VAL_W-1:0]  acc_r;
  logic                       found_r;
  logic                       sat_r;

  logic row_ok;
  logic more;
  logic match;
  logic is_get;
  logic is_mul;

  assign row_ok = ({1'b0, req_r.row} < row_count);
  assign more   = (k_r < end_r);
  assign match  = rsp.col_valid && (rsp.col_idx == req_r.col);
  assign is_get = (req_r.req_type == csm_pkg::REQ_GET);
  assign is_mul = (req_r.req_type == csm_pkg::REQ_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csm_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = csm_pkg::ST_DECODE;
        end
      end
      csm_pkg::ST_DECODE: begin
        unique case (req_r.req_type)
          csm_pkg::REQ_SET,
          csm_pkg::REQ_ADD: state_nxt = row_ok ? csm_pkg::ST_START : csm_pkg::ST_IDLE;
          csm_pkg::REQ_GET,
          csm_pkg::REQ_MUL: state_nxt = row_ok ? csm_pkg::ST_START : csm_pkg::ST_RESULT;
          default:          state_nxt = csm_pkg::ST_IDLE;
        endcase
      end
      csm_pkg::ST_START: state_nxt = csm_pkg::ST_END;
      csm_pkg::ST_END:   state_nxt = csm_pkg::ST_SCAN;
      csm_pkg::ST_SCAN: begin
        if (more) begin
          state_nxt = csm_pkg::ST_CHECK;
        end else if (is_get || is_mul) begin
          state_nxt = csm_pkg::ST_RESULT;
        end else begin
          state_nxt = csm_pkg::ST_IDLE;
        end
      end
      csm_pkg::ST_CHECK: begin
        state_nxt = (is_mul && rsp.col_valid) ? csm_pkg::ST_MUL : csm_pkg::ST_SCAN;
      end
      csm_pkg::ST_MUL: state_nxt = csm_pkg::ST_ACC;
      csm_pkg::ST_ACC: state_nxt = csm_pkg::ST_SCAN;
      csm_pkg::ST_RESULT: begin
        if (res_ready) begin
          state_nxt = csm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = csm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mreq      = '0;
    actl      = '0;
    mul_a     = rsp.val_rdata;
    mul_b     = rsp.x_rdata;
    add_a     = acc_r;
    add_b     = req_r.value;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      csm_pkg::ST_IDLE: in_ready = !rsp.busy;
      csm_pkg::ST_DECODE: begin
        unique case (req_r.req_type)
          csm_pkg::REQ_LOAD_X: begin
            mreq.x_we    = 1'b1;
            mreq.x_addr  = req_r.col;
            mreq.x_wdata = req_r.value;
          end
          csm_pkg::REQ_LOAD_END: begin
            mreq.end_we    = row_ok;
            mreq.end_addr  = req_r.row;
            mreq.end_wdata = (req_r.pointer > csm_pkg::NNZ_PTR) ? csm_pkg::NNZ_PTR
                                                                 : req_r.pointer;
          end
          csm_pkg::REQ_LOAD_COL: begin
            mreq.slot_we   = 1'b1;
            mreq.val_we    = 1'b1;
            mreq.slot_addr = req_r.slot;
            mreq.col_wdata = req_r.col;
            mreq.val_wdata = '0;
          end
          csm_pkg::REQ_SET,
          csm_pkg::REQ_ADD,
          csm_pkg::REQ_GET,
          csm_pkg::REQ_MUL: begin
            // fetch the previous row's end as this row's start
            mreq.end_re   = row_ok;
            mreq.end_addr = req_r.row - csm_pkg::ROW_W'(1);
          end
          default: ;
        endcase
      end
      csm_pkg::ST_START: begin
        mreq.end_re   = 1'b1;
        mreq.end_addr = req_r.row;
      end
      csm_pkg::ST_SCAN: begin
        mreq.slot_re   = more;
        mreq.slot_addr = k_r[csm_pkg::SLOT_W-1:0];
      end
      csm_pkg::ST_CHECK: begin
        mreq.slot_addr = k_r[csm_pkg::SLOT_W-1:0];
        add_a          = rsp.val_rdata;
        if (req_r.req_type == csm_pkg::REQ_SET) begin
          mreq.val_we    = match;
          mreq.val_wdata = req_r.value;
        end else if (req_r.req_type == csm_pkg::REQ_ADD) begin
          mreq.val_we    = match;
          mreq.val_wdata = alu_sum;
        end else if (is_mul) begin
          mreq.x_re   = rsp.col_valid;
          mreq.x_addr = rsp.col_idx;
        end
      end
      csm_pkg::ST_MUL: actl.mul_en = 1'b1;
      csm_pkg::ST_ACC: actl.sel_acc = 1'b1;
      csm_pkg::ST_RESULT: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      csm_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          req_r <= in_req;
        end
      end
      csm_pkg::ST_DECODE: begin
        acc_r        <= '0;
        found_r      <= 1'b0;
        sat_r        <= 1'b0;
        res_r.value  <= '0;
        res_r.row    <= req_r.row;
        res_r.kind   <= is_mul ? csm_pkg::KIND_MUL : csm_pkg::KIND_GET;
        res_r.status <= csm_pkg::STATUS_ROW;
      end
      csm_pkg::ST_START: k_r <= (req_r.row == '0) ? '0 : rsp.end_rdata;
      csm_pkg::ST_END:   end_r <= rsp.end_rdata;
      csm_pkg::ST_SCAN: begin
        if (!more) begin
          res_r.value <= acc_r;
          if (is_get) begin
            res_r.status <= found_r ? csm_pkg::STATUS_OK : csm_pkg::STATUS_NOT_FOUND;
          end else begin
            res_r.status <= sat_r ? csm_pkg::STATUS_SAT : csm_pkg::STATUS_OK;
          end
        end
      end
      csm_pkg::ST_CHECK: begin
        if (!(is_mul && rsp.col_valid)) begin
          k_r <= k_r + csm_pkg::PTR_W'(1);
        end
        if (is_get && match) begin
          acc_r   <= rsp.val_rdata;   // keep the last match
          found_r <= 1'b1;
        end
      end
      csm_pkg::ST_ACC: begin
        acc_r <= alu_sum;
        sat_r <= sat_r | alu_sat;
        k_r   <= k_r + csm_pkg::PTR_W'(1);
      end
      default: ;
    endcase
  end

  assign res = res_r;

endmodule

@@ src/csr_sparse_matrix_engine.sv @@
`timescale 1ns / 1ps
// Top level of the CSR sparse matrix engine: ports, config register, result register.
// Depends on csm_pkg, csm_store, csm_alu and csm_ctrl.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   req_type, row, col, slot, pointer, value
//   out_     output     out_valid / out_ready result_value, result_row, result_kind, status
//   cfg_     input      cfg_valid / cfg_ready cfg_data (row_count)
//
// Load requests are accepted, then write storage from the decode state (a column load
//   writes both slot memories). Set, add, get and multiply walk the row's slots one
//   at a time through the single slot memory port; each occupied slot of a multiply
//   adds an x read and a pass through the shared multiplier.
// After reset the column memory is swept empty, one slot per cycle: in_ready stays
//   low until the sweep ends. Config writes are taken at any time.
// A result sits in the output register; the engine accepts the next item while it
//   waits, and stalls only when a second result finds the register still full.
module csr_sparse_matrix_engine (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [csm_pkg::REQ_W-1:0]         in_req_type,
  input  logic [csm_pkg::ROW_W-1:0]         in_row,
  input  logic [csm_pkg::COL_W-1:0]         in_col,
  input  logic [csm_pkg::SLOT_W-1:0]        in_slot,
  input  logic [csm_pkg::PTR_W-1:0]         in_pointer,
  input  logic signed [csm_pkg::VAL_W-1:0]  in_value,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [csm_pkg::VAL_W-1:0]  out_result_value,
  output logic [csm_pkg::ROW_W-1:0]         out_result_row,
  output logic                              out_result_kind,
  output logic [csm_pkg::STS_W-1:0]         out_status,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csm_pkg::RC_W-1:0]          cfg_data
);

  csm_pkg::req_t      in_req;
  csm_pkg::mem_req_t  mreq;
  csm_pkg::mem_rsp_t  mrsp;
  csm_pkg::alu_ctl_t  actl;
  csm_pkg::res_t      res;
  csm_pkg::res_t      out_q_r;

  logic [csm_pkg::RC_W-1:0]   row_count_r;
  logic [csm_pkg::VAL_W-1:0]  mul_a;
  logic [csm_pkg::VAL_W-1:0]  mul_b;
  logic [csm_pkg::VAL_W-1:0]  add_a;
  logic [csm_pkg::VAL_W-1:0]  add_b;
  logic [csm_pkg::VAL_W-1:0]  alu_sum;
  logic                       alu_sat;
  logic                       res_valid;
  logic                       res_ready;
  logic                       out_valid_r;
  logic                       out_valid_nxt;

  // Bundle the input item for the sequencer.
  always_comb begin
    in_req.req_type = csm_pkg::req_type_t'(in_req_type);
    in_req.row      = in_row;
    in_req.col      = in_col;
    in_req.slot     = in_slot;
    in_req.pointer  = in_pointer;
    in_req.value    = in_value;
  end

  // Row count register: always ready; write it only while no item is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= csm_pkg::ROW_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      row_count_r <= cfg_data;
    end
  end

  csm_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  csm_alu u_alu (
    .clk   (clk),
    .ctl   (actl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .add_a (add_a),
    .add_b (add_b),
    .sum   (alu_sum),
    .sat   (alu_sat)
  );

  csm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .row_count (row_count_r),
    .rsp       (mrsp),
    .mreq      (mreq),
    .actl      (actl),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .add_a     (add_a),
    .add_b     (add_b),
    .alu_sum   (alu_sum),
    .alu_sat   (alu_sat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: take a new result when empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_q_r.value;
  assign out_result_row   = out_q_r.row;
  assign out_result_kind  = out_q_r.kind;
  assign out_status       = out_q_r.status;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the CSR sparse matrix engine: directed tests, then random traffic.
// Depends on csm_pkg and the csr_sparse_matrix_engine RTL only.
module tb_top;
  import csm_pkg::*;

  // Opcode 7 is unused by the engine; send it as noise and expect nothing back.
  localparam logic [REQ_W-1:0] REQ_NONE = 3'd7;

  localparam int     HALF_PERIOD = 6;
  localparam int     RESET_CYCLES = 11;
  localparam int     ITEM_TARGET = 1950;
  // Worst single gap: multiply over a full 1024-slot row, plus stalls.
  localparam int     STALL_LIMIT = 25000;
  localparam int     LONG_HOLD = 400;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     TAIL_CYCLES = 64;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [REQ_W-1:0]  op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic [PTR_W-1:0]  pointer;
    logic [VAL_W-1:0]  value;
  } request_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_ready;
  logic [REQ_W-1:0]         in_req_type;
  logic [ROW_W-1:0]         in_row;
  logic [COL_W-1:0]         in_col;
  logic [SLOT_W-1:0]        in_slot;
  logic [PTR_W-1:0]         in_pointer;
  logic signed [VAL_W-1:0]  in_value;

  logic                     out_valid;
  logic                     out_ready;
  logic signed [VAL_W-1:0]  out_result_value;
  logic [ROW_W-1:0]         out_result_row;
  logic                     out_result_kind;
  logic [STS_W-1:0]         out_status;

  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [RC_W-1:0]          cfg_data;

  // Shadow copy of the engine state, updated as each item is accepted.
  logic [RC_W-1:0]          rows_active;
  logic [PTR_W-1:0]         end_ptr [ROWS];
  logic [COL_W-1:0]         slot_col [NNZ];
  bit                       slot_used [NNZ];
  logic signed [VAL_W-1:0]  slot_val [NNZ];
  logic signed [VAL_W-1:0]  xvec [COLS];

  res_t pending_answers [$];
  res_t oldest;
  int   mismatch_count = 0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  bit   fast_mode = 1'b0;
  int   sink_hold = 0;

  csr_sparse_matrix_engine u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_slot          (in_slot),
    .in_pointer       (in_pointer),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_result_row   (out_result_row),
    .out_result_kind  (out_result_kind),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Clamp to the signed 32-bit range and raise the flag on overflow.
  function automatic longint clamp32(input longint v, inout bit flag);
    if (v > SAT_HI) begin
      flag = 1'b1;
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      flag = 1'b1;
      return SAT_LO;
    end
    return v;
  endfunction

  // Slot range of row r: starts at the previous row's end, stops before its own.
  function automatic void row_span(input int r, output int lo, output int hi);
    lo = (r == 0) ? 0 : int'(end_ptr[r - 1]);
    hi = int'(end_ptr[r]);
  endfunction

  // Apply one request to the shadow matrix; return 1 with the answer when it yields one.
  function automatic bit csr_eval(input request_t rq, output res_t ans);
    bit     row_ok;
    bit     sat;
    bit     hit;
    int     lo;
    int     hi;
    longint acc;
    longint term;
    ans = '0;
    row_ok = rq.row < rows_active;
    lo = 0;
    hi = 0;
    acc = 0;
    sat = 1'b0;
    hit = 1'b0;
    if (row_ok) row_span(int'(rq.row), lo, hi);
    case (rq.op)
      REQ_LOAD_X: begin
        xvec[rq.col] = rq.value;
        return 1'b0;
      end
      REQ_LOAD_END: begin
        // Rows past row_count ignore the write; oversized ends clamp to the slot count.
        if (row_ok) end_ptr[rq.row] = (rq.pointer > NNZ_PTR) ? NNZ_PTR : rq.pointer;
        return 1'b0;
      end
      REQ_LOAD_COL: begin
        slot_used[rq.slot] = 1'b1;
        slot_col[rq.slot] = rq.col;
        slot_val[rq.slot] = '0;
        return 1'b0;
      end
      REQ_SET, REQ_ADD: begin
        // Every matching slot is updated, duplicates included.
        for (int k = lo; k < hi && k < NNZ; k++) begin
          if (slot_used[k] && slot_col[k] == rq.col) begin
            if (rq.op == REQ_SET) slot_val[k] = rq.value;
            else slot_val[k] = VAL_W'(clamp32(longint'(slot_val[k]) +
                                             longint'($signed(rq.value)), sat));
          end
        end
        return 1'b0;
      end
      REQ_GET: begin
        if (!row_ok) begin
          ans.status = STATUS_ROW;
        end else begin
          // Last match wins.
          for (int k = lo; k < hi && k < NNZ; k++) begin
            if (slot_used[k] && slot_col[k] == rq.col) begin
              acc = longint'(slot_val[k]);
              hit = 1'b1;
            end
          end
          if (!hit) ans.status = STATUS_NOT_FOUND;
        end
      end
      REQ_MUL: begin
        if (!row_ok) begin
          ans.status = STATUS_ROW;
        end else begin
          for (int k = lo; k < hi && k < NNZ; k++) begin
            if (slot_used[k]) begin
              // Arithmetic shift floors the Q16.16 product toward minus infinity.
              term = (longint'(slot_val[k]) * longint'(xvec[slot_col[k]])) >>> FRAC_BITS;
              acc = clamp32(acc + clamp32(term, sat), sat);
            end
          end
          if (sat) ans.status = STATUS_SAT;
        end
      end
      default: begin
        return 1'b0;
      end
    endcase
    ans.value = acc[VAL_W-1:0];
    ans.row = rq.row;
    ans.kind = (rq.op == REQ_MUL) ? KIND_MUL : KIND_GET;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic request_t make_req(input logic [REQ_W-1:0] op, input int row,
                                        input int col, input int slot, input int pointer,
                                        input logic [VAL_W-1:0] value);
    request_t rq;
    rq.op = op;
    rq.row = ROW_W'(row);
    rq.col = COL_W'(col);
    rq.slot = SLOT_W'(slot);
    rq.pointer = PTR_W'(pointer);
    rq.value = value;
    return rq;
  endfunction

  // Mostly small Q16.16 numbers, some extremes, some raw 32-bit noise.
  function automatic logic [VAL_W-1:0] random_value();
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    v = int'($urandom_range(0, 2 ** 20)) - 2 ** 19;
    case (pick)
      0, 1, 2, 3, 4: return VAL_W'(v);
      5: return VAL_MAX;
      6: return VAL_MIN;
      7: return '0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Prefer a column the row actually holds so that set, add and get hit.
  function automatic logic [COL_W-1:0] pick_column(input int r);
    int lo;
    int hi;
    int k;
    if (r < rows_active && $urandom_range(0, 3) != 0) begin
      row_span(r, lo, hi);
      if (hi > lo) begin
        k = $urandom_range(lo, hi - 1);
        if (slot_used[k]) return slot_col[k];
      end
    end
    return COL_W'($urandom_range(0, COLS - 1));
  endfunction

  // Present one item, hold it until accepted, then update the shadow state.
  // Valid is left high on return so back-to-back items never glitch it.
  task automatic send_item(input request_t rq);
    int   gap;
    res_t ans;
    gap = fast_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= rq.op;
    in_row      <= rq.row;
    in_col      <= rq.col;
    in_slot     <= rq.slot;
    in_pointer  <= rq.pointer;
    in_value    <= rq.value;
    do @(posedge clk); while (!in_ready);
    if (csr_eval(rq, ans)) pending_answers.push_back(ans);
    if (rq.op != REQ_NONE) items_sent++;
  endtask

  // Fence with a get on the top row, drop valid and wait for every answer.
  // The fence answer proves all earlier items (set and add included) retired.
  task automatic retire_all();
    send_item(make_req(REQ_GET, ROWS - 1, 0, $urandom, $urandom, $urandom));
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_count(input int rc);
    cfg_valid <= 1'b1;
    cfg_data  <= RC_W'(rc);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rows_active = RC_W'(rc);
  endtask

  // One traffic phase: reprogram row_count, load x, rebuild the row structure, fill slot
  // columns, then mix set/add/get/multiply with some noise and broken updates.
  task automatic run_csr_phase(input int rc, input int base, input int n_ops, input bit fast,
                               input bit load_all_x, input int hold);
    request_t rq;
    int       cum;
    int       lo;
    int       hi;
    int       r;
    int       pick;
    logic [COL_W-1:0] prev_col;
    retire_all();
    write_row_count(rc);
    fast_mode = fast;
    for (int c = 0; c < COLS; c++) begin
      if (load_all_x || $urandom_range(0, 7) == 0)
        send_item(make_req(REQ_LOAD_X, $urandom, c, $urandom, $urandom, random_value()));
    end
    // Row ends accumulate a few slots per row; a large base pushes rows past the end.
    cum = base;
    for (int i = 0; i < rc; i++) begin
      cum += $urandom_range(0, 6);
      send_item(make_req(REQ_LOAD_END, i, $urandom, $urandom, (cum > 2047) ? 2047 : cum,
                         $urandom));
    end
    for (int i = 0; i < rc; i++) begin
      row_span(i, lo, hi);
      prev_col = COL_W'($urandom);
      if (hi > lo && hi - lo <= 16) begin
        for (int k = lo; k < hi; k++) begin
          // Leave a few slots as they were; repeat a column now and then.
          if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 3) != 0) prev_col = COL_W'($urandom);
            send_item(make_req(REQ_LOAD_COL, $urandom, prev_col, k, $urandom, $urandom));
          end
        end
      end else if (hi > lo) begin
        repeat (8) send_item(make_req(REQ_LOAD_COL, $urandom, $urandom,
                                      $urandom_range(lo, hi - 1), $urandom, $urandom));
      end
    end
    sink_hold = hold;
    repeat (n_ops) begin
      pick = $urandom_range(0, 99);
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ROWS - 1) : $urandom_range(0, rc - 1);
      rq = make_req(REQ_GET, r, pick_column(r), $urandom, $urandom, random_value());
      if (pick < 4) begin
        rq.op = REQ_NONE;
      end else if (pick < 7) begin
        rq.op = REQ_LOAD_COL;
        if (r < rc) begin
          row_span(r, lo, hi);
          if (hi > lo) rq.slot = SLOT_W'($urandom_range(lo, hi - 1));
        end
      end else if (pick < 9) begin
        // Nudge a live row end by a little; rejected rows get any pointer.
        rq.op = REQ_LOAD_END;
        if (r < rc) begin
          cum = int'(end_ptr[r]) + $urandom_range(0, 4) - 2;
          rq.pointer = PTR_W'((cum < 0) ? 0 : cum);
        end
      end else if (pick < 12) begin
        rq.op = REQ_LOAD_X;
      end else if (pick < 30) begin
        rq.op = REQ_SET;
      end else if (pick < 45) begin
        rq.op = REQ_ADD;
      end else if (pick >= 72) begin
        rq.op = REQ_MUL;
      end
      send_item(rq);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh after reset: nothing found, empty product, unused opcode ignored.
  task automatic test_empty_matrix();
    send_item(make_req(REQ_GET, 0, 0, 0, 0, '0));
    send_item(make_req(REQ_MUL, 5, 0, 0, 0, '0));
    send_item(make_req(REQ_NONE, ROWS - 1, COLS - 1, NNZ - 1, 2047, '1));
  endtask

  // Build a tiny matrix by hand: clamped and inverted rows, duplicate columns,
  // add overflow, not-found, saturated multiply and floor rounding.
  task automatic test_csr_access();
    send_item(make_req(REQ_LOAD_X, 0, 0, 0, 0, VAL_MAX));
    send_item(make_req(REQ_LOAD_X, 0, COLS - 1, 0, 0, VAL_MIN));
    send_item(make_req(REQ_LOAD_X, 0, 1, 0, 0, 32'h0000_0001));
    send_item(make_req(REQ_LOAD_END, 0, 0, 0, 3, '0));
    send_item(make_req(REQ_LOAD_END, 1, 0, 0, 2047, '0));
    send_item(make_req(REQ_LOAD_END, 2, 0, 0, 0, '0));
    send_item(make_req(REQ_LOAD_COL, 0, 0, 0, 0, '0));
    send_item(make_req(REQ_LOAD_COL, 0, COLS - 1, 1, 0, '0));
    send_item(make_req(REQ_LOAD_COL, 0, 0, 2, 0, '0));
    send_item(make_req(REQ_LOAD_COL, 0, 1, NNZ - 1, 0, '0));
    send_item(make_req(REQ_GET, 0, 0, 0, 0, '0));
    send_item(make_req(REQ_SET, 0, 0, 0, 0, 32'h4000_0000));
    send_item(make_req(REQ_ADD, 0, 0, 0, 0, VAL_MAX));
    send_item(make_req(REQ_SET, 0, COLS - 1, 0, 0, VAL_MIN));
    send_item(make_req(REQ_GET, 0, 0, 0, 0, '0));
    send_item(make_req(REQ_GET, 0, 5, 0, 0, '0));
    send_item(make_req(REQ_GET, 2, 0, 0, 0, '0));
    send_item(make_req(REQ_MUL, 0, 0, 0, 0, '0));
    send_item(make_req(REQ_SET, 1, 1, 0, 0, 32'hFFFF_FFFF));
    send_item(make_req(REQ_MUL, 1, 0, 0, 0, '0));
  endtask

  // Narrow row_count to one row: everything above it is rejected or ignored.
  task automatic test_row_limit();
    retire_all();
    write_row_count(1);
    send_item(make_req(REQ_GET, 1, 1, 0, 0, '0));
    send_item(make_req(REQ_MUL, ROWS - 1, 0, 0, 0, '0));
    send_item(make_req(REQ_SET, 1, 1, 0, 0, 32'h0005_0000));
    send_item(make_req(REQ_LOAD_END, 5, 0, 0, 9, '0));
    retire_all();
    write_row_count(64);
    send_item(make_req(REQ_GET, 1, 1, 0, 0, '0));
  endtask

  // Hold the result side for a long stretch while items keep coming.
  task automatic test_backpressure();
    run_csr_phase(64, 0, 120, 1'b1, 1'b1, LONG_HOLD);
  endtask

  task automatic test_random_traffic();
    int phase;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: run_csr_phase(64, 0, 160, 1'b0, 1'b1, 0);
        1: run_csr_phase(1, 0, 120, 1'b0, 1'b0, 0);
        2: run_csr_phase(8, 1000, 100, 1'b0, 1'b0, 0);
        3: run_csr_phase(64, 0, 160, 1'b1, 1'b0, 0);
        default: run_csr_phase($urandom_range(1, 64), $urandom_range(0, 20), 160,
                               (phase % 3) == 0, 1'b0, 0);
      endcase
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready gaps, plus a long hold when one is requested.
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      gap = fast_mode ? 0 : $urandom_range(0, 19);
      if (sink_hold > 0) begin
        gap = sink_hold;
        sink_hold = 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t ns: result expected none actual value %0h row %0d kind %0d status %0d",
                 $time, out_result_value, out_result_row, out_result_kind, out_status);
        mismatch_count++;
      end else begin
        oldest = pending_answers.pop_front();
        check_field("result_value", oldest.value, out_result_value);
        check_field("result_row", oldest.row, out_result_row);
        check_field("result_kind", oldest.kind, out_result_kind);
        check_field("status", oldest.status, out_status);
      end
    end
  end

  // Watchdog: count cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = '0;
    in_row      = '0;
    in_col      = '0;
    in_slot     = '0;
    in_pointer  = '0;
    in_value    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    rows_active = ROW_COUNT_RST;
    for (int i = 0; i < ROWS; i++) end_ptr[i] = '0;
    for (int i = 0; i < NNZ; i++) begin
      slot_used[i] = 1'b0;
      slot_col[i] = '0;
      slot_val[i] = '0;
    end
    for (int i = 0; i < COLS; i++) xvec[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_matrix();
    test_csr_access();
    test_row_limit();
    test_backpressure();
    test_random_traffic();

    // Drain, then give any stray result time to show up.
    retire_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
